[hdl/fst_pkg.sv]
// Package: flow tracker constants, types and status codes.
`default_nettype none
package fst_pkg;
    localparam int TableEntries = 64;
    localparam int IdxBits = $clog2(TableEntries);
    localparam int CntBits = IdxBits + 1;
    localparam int TimeBits = 32;

    localparam logic [3:0] ST_NONE = 4'd0;
    localparam logic [3:0] ST_CNCT = 4'd1;
    localparam logic [3:0] ST_PTRU = 4'd2;
    localparam logic [3:0] ST_EST  = 4'd3;
    localparam logic [3:0] ST_LFIN = 4'd4;
    localparam logic [3:0] ST_RFIN = 4'd5;
    localparam logic [3:0] ST_CLSD = 4'd6;
    localparam logic [3:0] ST_LRST = 4'd7;
    localparam logic [3:0] ST_RRST = 4'd8;
    localparam logic [3:0] ST_TOUT = 4'd9;

    localparam logic [1:0] REG_IDLE = 2'd0;
    localparam logic [1:0] REG_TCP  = 2'd1;
    localparam logic [1:0] REG_UDP  = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic        is_udp;
        logic        outbound;
        logic [31:0] local_addr;
        logic [15:0] loc_port;
        logic [31:0] remote_addr;
        logic [15:0] rem_port;
        logic [15:0] packet_length;
        logic        fin_flag;
        logic        syn_flag;
        logic        rst_flag;
        logic        ack_flag;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [5:0]  entry_index;
        logic        new_entry;
        logic        table_full;
        logic [3:0]  flow_status;
        logic [31:0] pkt_cnt_in;
        logic [31:0] pkt_cnt_out;
        logic [31:0] byte_cnt_in;
        logic [31:0] byte_cnt_out;
        logic [6:0]  removed_count;
        logic [6:0]  timed_out_count;
    } t_out;

    typedef struct packed {
        logic [15:0] idle_limit;
        logic [15:0] tcp_idle_max;
        logic [15:0] udp_idle_max;
    } t_cfg;

    function automatic logic [3:0] next_status(logic [3:0] st_in, logic udp, logic same,
                                               logic dir, logic fin, logic syn,
                                               logic rst, logic ack);
        logic [3:0] st;
        st = st_in;
        if (udp) begin
            if (st == ST_NONE) begin
                if (same) st = ST_CNCT;
            end else if (st == ST_CNCT) begin
                if (!same) st = ST_EST;
            end else if (st == ST_TOUT) begin
                st = ST_EST;
            end
        end else begin
            if (st == ST_NONE && same) st = ST_PTRU;
            if (st == ST_PTRU && !same) st = ST_EST;
            if (syn && !ack && same) st = ST_CNCT;
            if (syn && ack && !same) st = ST_EST;
            if (rst) st = dir ? ST_LRST : ST_RRST;
            if (fin) begin
                if (st == ST_LFIN) begin
                    if (!dir) st = ST_CLSD;
                end else if (st == ST_RFIN) begin
                    if (dir) st = ST_CLSD;
                end else begin
                    st = dir ? ST_LFIN : ST_RFIN;
                end
            end
        end
        return st;
    endfunction
endpackage
`default_nettype wire

[hdl/fst_stream_if.sv]
// Interface: valid/ready channel with a packed payload.
`default_nettype none
interface fst_in_if;
    logic          valid;
    logic          ready;
    fst_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fst_out_if;
    logic          valid;
    logic          ready;
    fst_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/fst_cfg_regs.sv]
// APB register file for the idle and timeout limits.
`default_nettype none
module fst_cfg_regs (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output fst_pkg::t_cfg o_cfg
);
    import fst_pkg::*;
    t_cfg r_cfg;
    logic [1:0] w_idx;
    assign w_idx = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_limit   <= 16'd5;
            r_cfg.tcp_idle_max <= 16'd300;
            r_cfg.udp_idle_max <= 16'd10;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_IDLE: r_cfg.idle_limit   <= pwdata[15:0];
                REG_TCP:  r_cfg.tcp_idle_max <= pwdata[15:0];
                REG_UDP:  r_cfg.udp_idle_max <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_IDLE: prdata = {16'd0, r_cfg.idle_limit};
            REG_TCP:  prdata = {16'd0, r_cfg.tcp_idle_max};
            REG_UDP:  prdata = {16'd0, r_cfg.udp_idle_max};
            default:  prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

[hdl/fst_engine.sv]
// Flow table and sequencer: serial key scan, update, and tick sweep.
`default_nettype none
module fst_engine (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire fst_pkg::t_cfg i_cfg,
    fst_in_if.sink        s_in,
    fst_out_if.source     m_out
);
    import fst_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RD, S_UPD, S_CNT, S_SWP, S_SWC, S_OUT} t_state;

    // Table memories, one entry read per cycle.
    logic [63:0]       m_key   [TableEntries];
    logic [32:0]       m_ports [TableEntries];
    logic [4:0]        m_stat  [TableEntries];
    logic [TimeBits-1:0] m_seen [TableEntries];
    logic [63:0]       m_cnt   [2*TableEntries];
    logic [TableEntries-1:0] r_valid;

    t_state r_state;
    t_in    r_in;
    t_out   r_out;
    logic   r_ovalid;
    logic [CntBits-1:0] r_ptr;
    logic [IdxBits-1:0] r_slot;
    logic   r_hit, r_free_ok;
    logic [IdxBits-1:0] r_free;
    logic [CntBits-1:0] r_rem, r_tmo;
    logic [TimeBits-1:0] r_now;
    logic [63:0] r_rkey;
    logic [32:0] r_rports;
    logic [4:0]  r_rstat;
    logic [TimeBits-1:0] r_rseen;
    logic [63:0] r_rci, r_rco;
    logic [IdxBits-1:0] w_p;
    logic [TimeBits-1:0] w_idle;
    logic [3:0] w_st;
    logic w_lim;

    assign w_p = r_ptr[IdxBits-1:0];
    assign s_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_out;
    assign w_idle = r_now - r_rseen;
    assign w_st = next_status(r_rstat[3:0], r_rports[32], r_rstat[4] == r_in.outbound,
                              r_in.outbound, r_in.fin_flag, r_in.syn_flag,
                              r_in.rst_flag, r_in.ack_flag);
    assign w_lim = r_rports[32] ? (w_idle >= TimeBits'(i_cfg.udp_idle_max))
                                : (w_idle >= TimeBits'(i_cfg.tcp_idle_max));

    // Registered memory reads at the scan pointer or the chosen slot.
    always_ff @(posedge i_clk) begin
        r_rkey   <= m_key[(r_state == S_RD) ? r_slot : w_p];
        r_rports <= m_ports[(r_state == S_RD) ? r_slot : w_p];
        r_rstat  <= m_stat[(r_state == S_RD) ? r_slot : w_p];
        r_rseen  <= m_seen[w_p];
        r_rci    <= m_cnt[{r_slot, 1'b0}];
        r_rco    <= m_cnt[{r_slot, 1'b1}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_valid  <= '0;
            r_now    <= '0;
        end else begin
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_in.valid && s_in.ready) begin
                    r_in <= s_in.data;
                    r_ptr <= '0;
                    r_hit <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_rem <= '0;
                    r_tmo <= '0;
                    r_out <= '0;
                    if (s_in.data.cmd) begin
                        r_now <= r_now + 1'b1;
                        r_state <= S_SWP;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Read for entry r_ptr-1 is in the read registers.
                    if (r_ptr != '0) begin
                        if (r_valid[w_p - 1'b1]) begin
                            if (!r_hit && r_rports[32] == r_in.is_udp
                                && r_rkey == {r_in.local_addr, r_in.remote_addr}
                                && r_rports[31:0] == {r_in.loc_port, r_in.rem_port}) begin
                                r_hit <= 1'b1;
                                r_slot <= w_p - 1'b1;
                            end
                        end else if (!r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free <= w_p - 1'b1;
                        end
                    end
                    if (r_ptr == CntBits'(TableEntries)) r_state <= S_RD;
                    else r_ptr <= r_ptr + 1'b1;
                end
                S_RD: begin
                    if (!r_hit) begin
                        if (!r_free_ok) begin
                            r_out.table_full <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_slot <= r_free;
                            r_valid[r_free] <= 1'b1;
                            m_key[r_free] <= {r_in.local_addr, r_in.remote_addr};
                            m_ports[r_free] <= {r_in.is_udp, r_in.loc_port,
                                                r_in.rem_port};
                            m_stat[r_free] <= {r_in.outbound, ST_NONE};
                            m_cnt[{r_free, 1'b0}] <= '0;
                            m_cnt[{r_free, 1'b1}] <= '0;
                            r_out.new_entry <= 1'b1;
                            r_hit <= 1'b1;
                        end
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    m_seen[r_slot] <= r_now;
                    m_stat[r_slot] <= {r_rstat[4], w_st};
                    r_out.flow_status <= w_st;
                    r_out.entry_index <= 6'(r_slot);
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    if (r_in.outbound) begin
                        m_cnt[{r_slot, 1'b1}] <= {r_rco[63:32] + 32'd1,
                                                  r_rco[31:0] + 32'(r_in.packet_length)};
                        r_out.pkt_cnt_out <= r_rco[63:32] + 32'd1;
                        r_out.byte_cnt_out <= r_rco[31:0] + 32'(r_in.packet_length);
                        r_out.pkt_cnt_in <= r_rci[63:32];
                        r_out.byte_cnt_in <= r_rci[31:0];
                    end else begin
                        m_cnt[{r_slot, 1'b0}] <= {r_rci[63:32] + 32'd1,
                                                  r_rci[31:0] + 32'(r_in.packet_length)};
                        r_out.pkt_cnt_in <= r_rci[63:32] + 32'd1;
                        r_out.byte_cnt_in <= r_rci[31:0] + 32'(r_in.packet_length);
                        r_out.pkt_cnt_out <= r_rco[63:32];
                        r_out.byte_cnt_out <= r_rco[31:0];
                    end
                    r_state <= S_OUT;
                end
                S_SWP: r_state <= S_SWC; // wait for entry read
                S_SWC: begin
                    if (r_valid[w_p]) begin
                        if (r_rstat[3:0] != ST_EST
                            && w_idle >= TimeBits'(i_cfg.idle_limit)) begin
                            r_valid[w_p] <= 1'b0;
                            r_rem <= r_rem + 1'b1;
                        end else if (r_rstat[3:0] != ST_TOUT && w_lim) begin
                            m_stat[w_p] <= {r_rstat[4], ST_TOUT};
                            m_seen[w_p] <= r_now;
                            r_tmo <= r_tmo + 1'b1;
                        end
                    end
                    if (r_ptr == CntBits'(TableEntries - 1)) begin
                        r_out.kind <= 1'b1;
                        r_out.removed_count <= 7'(r_rem + (r_valid[w_p]
                            && r_rstat[3:0] != ST_EST
                            && w_idle >= TimeBits'(i_cfg.idle_limit)));
                        r_out.timed_out_count <= 7'(r_tmo + (r_valid[w_p]
                            && !(r_rstat[3:0] != ST_EST
                                 && w_idle >= TimeBits'(i_cfg.idle_limit))
                            && r_rstat[3:0] != ST_TOUT && w_lim));
                        r_state <= S_OUT;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                        r_state <= S_SWP;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/tcp_udp_flow_state_tracker_top.sv]
// Top level: TCP/UDP flow state tracker.
// Input channel s_in takes one beat per packet event or one-second tick.
// Output channel m_out returns one result beat per input beat, in order.
// A packet scans all 64 table entries through one registered read port,
// one entry a cycle, then updates status and counters.
// A tick walks all entries, each through a read wait (S_SWP) and a check (S_SWC).
// The block takes the next beat once its result has been taken;
// while the receiver stalls the result holds and input is not accepted.
// Reset (i_rst_n low, synchronous) empties the table, zeroes the seconds
// counter and restores limits to idle 5, TCP 300, UDP 10. No clearing
// pass is needed: entries are guarded by valid flip-flops.
// Limits are written over APB at byte addresses 0, 4, 8.
`default_nettype none
module tcp_udp_flow_state_tracker_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fst_in_if.sink      s_in,
    fst_out_if.source   m_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fst_pkg::*;
    t_cfg w_cfg;

    fst_cfg_regs u_cfg (.i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                        .prdata, .pready, .o_cfg(w_cfg));
    fst_engine u_eng (.i_clk, .i_rst_n, .i_cfg(w_cfg), .s_in, .m_out);

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !s_in.ready) else $error("input ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> m_out.valid) else $error("result dropped");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.data.kind) |-> (m_out.data.entry_index == 6'd0
            && !m_out.data.table_full)) else $error("tick result carries packet fields");
endmodule
`default_nettype wire
